### rtl/core/ltc_pkg.sv
// Types and constants shared by the LRU tag cache.
// No dependencies; imported by ltc_store, lru_tag_cache_unit and the testbench.
package ltc_pkg;

	localparam int KEY_W    = 32;
	localparam int HANDLE_W = 32;
	localparam int STAMP_W  = 32;
	localparam int SLOT_W   = 4;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
		logic [STAMP_W-1:0]  stamp;
	} entry_t;

	typedef struct packed {
		logic                evicted;
		logic [SLOT_W-1:0]   slot;
		logic [HANDLE_W-1:0] handle_out;
		logic                hit;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MISS,
		ST_MIN,
		ST_RESP
	} st_t;

endpackage

### rtl/core/lru_tag_cache_unit.sv
// Channel  | dir | tdata (low bit up)                               | tuser
// s_axis   | in  | key[31:0], handle[63:32]                         | cmd (0 lookup, 1 insert)
// m_axis   | out | hit[0], handle_out[32:1], slot[36:33], evicted[37] | -
//
// One beat at a time. The entry memory is walked one slot per cycle through
// its registered read port: a lookup or a present-key insert walks up to the
// matching slot, a miss walks all filled slots, and an insert into a full
// cache adds a second walk over all ENTRIES for the oldest stamp. An insert
// with a zero handle answers without a walk and stores nothing.
// Reset clears fill count, access clock and control; memory contents are not
// cleared. The result waits in an output register, so a stalled m_axis does
// not hold the input side until the next result is ready.
module lru_tag_cache_unit
	import ltc_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // key[31:0], handle[63:32]
	input  logic        s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // hit, handle_out, slot, evicted, zero pad
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	st_t                 state_q, state_d;
	logic                cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [IDX_W-1:0]    scan_q, scan_d;
	logic [CNT_W-1:0]    fill_q, fill_d;
	logic [STAMP_W-1:0]  clock_q, clock_d;
	logic [STAMP_W-1:0]  min_q, min_d;
	logic [IDX_W-1:0]    best_q, best_d;
	res_t                res_q, res_d;
	logic                out_valid_q;
	res_t                out_q;
	logic                out_load;

	logic [IDX_W-1:0]    rd_addr;
	entry_t              rd_entry;
	logic                mem_we;
	logic [IDX_W-1:0]    wr_addr;
	entry_t              wr_data;

	logic [STAMP_W-1:0]  stamp_new;
	logic                key_match, last_fill, last_ent, take_min, has_room, out_free;
	logic [IDX_W-1:0]    best_n, fill_idx, scan_nx;
	logic                in_beat;

	ltc_store #(.ENTRIES(ENTRIES)) u_store (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_entry),
		.wr_en   (mem_we),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	assign stamp_new = clock_q + STAMP_W'(1);
	assign key_match = (rd_entry.key == key_q);
	assign last_fill = (scan_q == IDX_W'(fill_q - CNT_W'(1)));
	assign last_ent  = (scan_q == IDX_W'(ENTRIES - 1));
	assign take_min  = (scan_q == '0) || (rd_entry.stamp < min_q);
	assign best_n    = take_min ? scan_q : best_q;
	assign has_room  = (fill_q != CNT_W'(ENTRIES));
	assign fill_idx  = fill_q[IDX_W-1:0];
	assign scan_nx   = IDX_W'(scan_q + IDX_W'(1));
	assign out_free  = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d  = state_q;
		scan_d   = scan_q;
		fill_d   = fill_q;
		clock_d  = clock_q;
		min_d    = min_q;
		best_d   = best_q;
		res_d    = res_q;
		out_load = 1'b0;
		rd_addr  = scan_q;
		mem_we   = 1'b0;
		wr_addr  = scan_q;
		wr_data  = '{key: key_q, handle: handle_q, stamp: stamp_new};
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					if (s_axis_tuser == CMD_INSERT && s_axis_tdata[63:32] == '0) begin
						res_d   = '0;
						state_d = ST_RESP;
					end else if (fill_q == '0) begin
						state_d = ST_MISS;
					end else begin
						rd_addr = '0;
						scan_d  = '0;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (key_match) begin
					// restamp in place, key and handle written back unchanged
					mem_we  = 1'b1;
					wr_addr = scan_q;
					wr_data = '{key: rd_entry.key, handle: rd_entry.handle, stamp: stamp_new};
					clock_d = stamp_new;
					res_d   = '{evicted: 1'b0, slot: SLOT_W'(scan_q),
						handle_out: (cmd_q == CMD_LOOKUP) ? rd_entry.handle : '0,
						hit: 1'b1};
					state_d = ST_RESP;
				end else if (last_fill) begin
					state_d = ST_MISS;
				end else begin
					rd_addr = scan_nx;
					scan_d  = scan_nx;
				end
			end
			ST_MISS: begin
				if (cmd_q == CMD_LOOKUP) begin
					res_d   = '0;
					state_d = ST_RESP;
				end else if (has_room) begin
					mem_we  = 1'b1;
					wr_addr = fill_idx;
					clock_d = stamp_new;
					fill_d  = CNT_W'(fill_q + CNT_W'(1));
					res_d   = '{evicted: 1'b0, slot: SLOT_W'(fill_idx), handle_out: '0,
						hit: 1'b0};
					state_d = ST_RESP;
				end else begin
					rd_addr = '0;
					scan_d  = '0;
					state_d = ST_MIN;
				end
			end
			ST_MIN: begin
				// strict less-than keeps the lowest slot on equal stamps
				min_d  = take_min ? rd_entry.stamp : min_q;
				best_d = best_n;
				if (last_ent) begin
					mem_we  = 1'b1;
					wr_addr = best_n;
					clock_d = stamp_new;
					res_d   = '{evicted: 1'b1, slot: SLOT_W'(best_n), handle_out: '0,
						hit: 1'b0};
					state_d = ST_RESP;
				end else begin
					rd_addr = scan_nx;
					scan_d  = scan_nx;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			fill_q      <= '0;
			clock_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
			fill_q  <= fill_d;
			clock_q <= clock_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			cmd_q    <= s_axis_tuser;
			key_q    <= s_axis_tdata[31:0];
			handle_q <= s_axis_tdata[63:32];
		end
		min_q  <= min_d;
		best_q <= best_d;
		res_q  <= res_d;
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(ENTRIES))
		else $error("fill count beyond capacity");

	a_clock_with_write: assert property (@(posedge clk) disable iff (!arst_n)
		(clock_q != $past(clock_q)) |-> $past(mem_we))
		else $error("access clock moved without an entry write");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_SCAN || state_q == ST_MISS || state_q == ST_MIN))
		else $error("entry write outside a scan or fill state");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.hit && out_q.evicted))
		else $error("result marked both hit and evicted");

	a_fill_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> ($past(state_q) == ST_MISS && $past(cmd_q) == CMD_INSERT))
		else $error("fill count changed outside an insert into a free slot");

endmodule

### rtl/core/ltc_store.sv
// Entry memory of the LRU tag cache: key, handle and stamp per slot.
// One write port, one read port, read data registered. Uses ltc_pkg.
module ltc_store
	import ltc_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic                       clk,
	input  logic [$clog2(ENTRIES)-1:0] rd_addr,
	output entry_t                     rd_data,
	input  logic                       wr_en,
	input  logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  entry_t                     wr_data
);

	entry_t mem [ENTRIES];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

### verif/testbench.sv
// Self-checking bench for lru_tag_cache_unit: a scoreboard predicts each result
// beat from the accepted input beats. Depends on ltc_pkg and the cache RTL only.

class lru_scoreboard;
	localparam int N_ENTRIES = 16;

	// predictor state
	logic [31:0]     key_mem[N_ENTRIES];
	logic [31:0]     handle_mem[N_ENTRIES];
	logic [31:0]     stamp_mem[N_ENTRIES];
	int unsigned     fill_count;
	logic [31:0]     access_clock;

	ltc_pkg::res_t   expected_q[$];
	int              mismatches;
	int              lookups, inserts, hits, evictions, dropped;

	function new();
		fill_count   = 0;
		access_clock = '0;
		mismatches   = 0;
		lookups      = 0;
		inserts      = 0;
		hits         = 0;
		evictions    = 0;
		dropped      = 0;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void stamp_entry(int idx);
		access_clock   = access_clock + 32'd1;
		stamp_mem[idx] = access_clock;
	endfunction

	function void flag_error(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
	endfunction

	// input beat accepted: work out the cache's answer and update the state
	function void note_input(logic cmd, logic [31:0] key, logic [31:0] handle);
		ltc_pkg::res_t r;
		int match, victim;
		r     = '0;
		match = -1;
		for (int i = 0; i < fill_count; i++)
			if (match < 0 && key_mem[i] == key)
				match = i;
		if (cmd == ltc_pkg::CMD_LOOKUP) begin
			lookups++;
			if (match >= 0) begin
				stamp_entry(match);
				r.hit        = 1'b1;
				r.handle_out = handle_mem[match];
				r.slot       = match[3:0];
				hits++;
			end
		end else begin
			inserts++;
			if (handle == '0) begin
				dropped++;
			end else if (match >= 0) begin
				// present key: old handle stays, only the stamp moves
				stamp_entry(match);
				r.hit  = 1'b1;
				r.slot = match[3:0];
			end else if (fill_count < N_ENTRIES) begin
				key_mem[fill_count]    = key;
				handle_mem[fill_count] = handle;
				stamp_entry(fill_count);
				r.slot = fill_count[3:0];
				fill_count++;
			end else begin
				victim = 0;
				for (int i = 1; i < N_ENTRIES; i++)
					if (stamp_mem[i] < stamp_mem[victim])
						victim = i;
				key_mem[victim]    = key;
				handle_mem[victim] = handle;
				stamp_entry(victim);
				r.slot    = victim[3:0];
				r.evicted = 1'b1;
				evictions++;
			end
		end
		expected_q.push_back(r);
	endfunction

	function void check_result(logic [39:0] tdata);
		ltc_pkg::res_t want;
		if (expected_q.size() == 0) begin
			flag_error("unexpected result beat", '0, tdata);
			return;
		end
		want = expected_q.pop_front();
		if (tdata[0] !== want.hit)
			flag_error("hit", want.hit, tdata[0]);
		if (tdata[32:1] !== want.handle_out)
			flag_error("handle_out", want.handle_out, tdata[32:1]);
		if (tdata[36:33] !== want.slot)
			flag_error("slot", want.slot, tdata[36:33]);
		if (tdata[37] !== want.evicted)
			flag_error("evicted", want.evicted, tdata[37]);
	endfunction
endclass

module testbench
	import ltc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ENTRIES  = 16;
	localparam int RAND_ITEMS = 1900;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;

	lru_scoreboard cache_sb = new();
	bit            hold_req = 1'b0;
	int            burst_left = 0;
	logic [31:0]   key_pool[32];
	int            pool_size;

	lru_tag_cache_unit #(.ENTRIES(N_ENTRIES)) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result beat checked before input beat of the same edge
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			cache_sb.check_result(m_axis_tdata);
		if (s_axis_tvalid && s_axis_tready)
			cache_sb.note_input(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
	end

	// receiver: stretches of differing stall density, plus one long hold-off on request
	initial begin
		int mode, stretch;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				mode    = $urandom_range(3);
				stretch = $urandom_range(200, 20);
				repeat (stretch) begin
					case (mode)
						0: m_axis_tready <= 1'b1;
						1: m_axis_tready <= ($urandom_range(1) == 1);
						2: m_axis_tready <= ($urandom_range(3) == 0);
						default: m_axis_tready <= ($urandom_range(7) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	task automatic send_beat(input logic cmd, input logic [31:0] key, input logic [31:0] handle);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {handle, key};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic sender_gap(input int cycles);
		s_axis_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// bursts of beats separated by idle gaps; some gaps are zero
	task automatic paced_beat(input logic cmd, input logic [31:0] key, input logic [31:0] handle);
		if (burst_left == 0) begin
			if ($urandom_range(3) != 0)
				sender_gap($urandom_range(12, 1));
			burst_left = $urandom_range(24, 1);
		end
		send_beat(cmd, key, handle);
		burst_left--;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (cache_sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic refill_pool();
		pool_size = $urandom_range(32, 8);
		foreach (key_pool[i])
			key_pool[i] = $urandom();
		key_pool[0] = '0;
		key_pool[1] = '1;
	endtask

	initial begin
		#20_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		logic        cmd;
		logic [31:0] key, handle;
		int          waited;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty miss, dropped insert, field extremes, re-insert, fill, evict
		send_beat(CMD_LOOKUP, 32'h1234_5678, 32'h0);
		send_beat(CMD_INSERT, 32'hDEAD_BEEF, 32'h0);
		send_beat(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_beat(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0001);
		send_beat(CMD_LOOKUP, 32'h0000_0000, 32'h0);
		send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(CMD_INSERT, 32'h0000_0000, 32'h5555_AAAA);
		send_beat(CMD_LOOKUP, 32'h0000_0000, 32'h0);
		for (int i = 0; i < N_ENTRIES - 2; i++)
			send_beat(CMD_INSERT, 32'hA5A5_0000 + i, 32'h0100_0000 + i);
		send_beat(CMD_INSERT, 32'h5A5A_5A5A, 32'hAAAA_5555);
		send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		send_beat(CMD_LOOKUP, 32'h5A5A_5A5A, 32'h0);
		drain_results();

		refill_pool();
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 300 == 299)
				refill_pool();
			if (n == 600)
				hold_req = 1'b1;
			if (n == 1200)
				drain_results();
			cmd = ($urandom_range(1) == 1) ? CMD_INSERT : CMD_LOOKUP;
			if ($urandom_range(9) < 8)
				key = key_pool[$urandom_range(pool_size - 1)];
			else
				key = $urandom();
			case ($urandom_range(19))
				0: handle = '0;
				1: handle = '1;
				default: handle = $urandom();
			endcase
			paced_beat(cmd, key, handle);
		end
		s_axis_tvalid <= 1'b0;

		waited = 0;
		while (cache_sb.pending() != 0 && waited < 50_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * N_ENTRIES + 10) @(posedge clk);
		if (cache_sb.pending() != 0)
			cache_sb.mismatches += cache_sb.pending();

		$display("run: %0d lookups (%0d hits), %0d inserts (%0d dropped, %0d evictions)",
			cache_sb.lookups, cache_sb.hits, cache_sb.inserts, cache_sb.dropped,
			cache_sb.evictions);
		$display("run: %0d failures in total", cache_sb.mismatches);
		if (cache_sb.mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
